@@ rtl/grid_maze_longest_path_core_assert.svh @@
// Assertion macros shared by the grid maze longest path RTL.
`ifndef GRID_MAZE_LONGEST_PATH_CORE_ASSERT_SVH
`define GRID_MAZE_LONGEST_PATH_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GML_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GML_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/gml_pkg.sv @@
// Constants, types and helper functions of the grid maze longest path core.
package gml_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int DROW_W  = ROW_W + 1;
   localparam int DCOL_W  = COL_W + 1;
   localparam int CELL_W  = $clog2(CELL_COUNT);
   localparam int TOTAL_W = CELL_W + 1;

   localparam int CFG_W     = 7;
   localparam int LEN_W     = 12;
   localparam int LEN_MAX   = 4095;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b1;
   localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_SEED,
      ST_EXPAND,
      ST_CHECK,
      ST_POP,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      DIR_DOWN,
      DIR_UP,
      DIR_RIGHT,
      DIR_LEFT,
      DIR_DONE
   } dir_type;

   typedef struct packed {
      logic [CELL_W-1:0] spot;
      logic [1:0]        dir;
   } stack_entry_type;

   function automatic logic [DROW_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DROW_W'(1);
      end
      if (int'(v) > MAX_ROWS) begin
         return DROW_W'(MAX_ROWS);
      end
      return DROW_W'(v);
   endfunction

   function automatic logic [DCOL_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DCOL_W'(1);
      end
      if (int'(v) > MAX_COLS) begin
         return DCOL_W'(MAX_COLS);
      end
      return DCOL_W'(v);
   endfunction

endpackage

@@ rtl/gml_if.sv @@
// Request and response channel interfaces of the grid maze longest path core.
interface gml_req_if;
   logic valid;
   logic ready;
   logic cell_open;
   logic last_cell;

   modport source (output valid, output cell_open, output last_cell, input ready);
   modport sink   (input valid, input cell_open, input last_cell, output ready);
endinterface

interface gml_rsp_if;
   import gml_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] path_length;
   logic             no_open_cell;

   modport source (output valid, output path_length, output no_open_cell, input ready);
   modport sink   (input valid, input path_length, input no_open_cell, output ready);
endinterface

@@ rtl/gml_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module gml_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/grid_maze_longest_path_core.sv @@
// Top level of the grid maze longest path core: cell loader, two depth-first walks, result.
// A last cell starts a scan for the start cell over the grid in use, then the first walk, a
// clearing pass of the visited bits and the second walk from the deepest cell of the first.
// Throughput: one request a cycle while loading, set by the single write port of the open map.
// Reset: synchronous; control state and configuration registers return to their defaults, memories keep data.
`include "grid_maze_longest_path_core_assert.svh"

module grid_maze_longest_path_core (
   input  logic                           clock,
   input  logic                           reset,
   gml_req_if.sink                        req_chan,
   gml_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [gml_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gml_pkg::CFG_W-1:0]      csr_wdata
);
   import gml_pkg::*;

   // Configuration registers and the clamped grid size derived from them.
   logic [CFG_W-1:0]   csr_rows_ff;
   logic [CFG_W-1:0]   csr_cols_ff;
   logic [DROW_W-1:0]  rows_c;
   logic [DCOL_W-1:0]  cols_c;
   logic [TOTAL_W-1:0] total;

   // Sequencer state.
   state_type          state_ff, state_in;
   logic [TOTAL_W-1:0] load_pos_ff, load_pos_in;
   logic               walk2_ff, walk2_in;

   // Sweep counter used by the start scan and by the visited clearing pass.
   logic [CELL_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [ROW_W-1:0]   scan_row_ff, scan_row_in;
   logic [COL_W-1:0]   scan_col_ff, scan_col_in;
   logic               scan_pv_ff, scan_pv_in;
   logic [CELL_W-1:0]  scan_pidx_ff;
   logic [ROW_W-1:0]   scan_prow_ff;
   logic [COL_W-1:0]   scan_pcol_ff;

   // Start cell of the first walk.
   logic               found_ff, found_in;
   logic [CELL_W-1:0]  start_cell_ff, start_cell_in;
   logic [ROW_W-1:0]   start_row_ff, start_row_in;
   logic [COL_W-1:0]   start_col_ff, start_col_in;

   // Top of the walk stack lives in registers; the entries below it live in the stack RAM.
   logic [CELL_W-1:0]  cur_cell_ff, cur_cell_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   dir_type            cur_dir_ff, cur_dir_in;
   logic [TOTAL_W-1:0] depth_ff, depth_in;

   // Neighbour being probed while its open and visited bits are read.
   logic [CELL_W-1:0]  nb_cell_ff, nb_cell_in;
   logic [ROW_W-1:0]   nb_row_ff, nb_row_in;
   logic [COL_W-1:0]   nb_col_ff, nb_col_in;
   logic [1:0]         nb_dir_ff, nb_dir_in;

   // Deepest cell found so far.
   logic [TOTAL_W-1:0] best_ff, best_in;
   logic [CELL_W-1:0]  far_cell_ff, far_cell_in;
   logic [ROW_W-1:0]   far_row_ff, far_row_in;
   logic [COL_W-1:0]   far_col_ff, far_col_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_none_ff, rsp_none_in;

   // Neighbour of the top cell in its current direction.
   logic               nb_ok;
   logic [CELL_W-1:0]  nb_cell;
   logic [ROW_W-1:0]   nb_row;
   logic [COL_W-1:0]   nb_col;

   // Memory ports.
   logic               open_we, open_wdata, open_rdata;
   logic [CELL_W-1:0]  open_waddr, open_raddr;
   logic               vis_we, vis_wdata, vis_rdata;
   logic [CELL_W-1:0]  vis_waddr, vis_raddr;
   logic               stk_we;
   logic [CELL_W-1:0]  stk_waddr, stk_raddr;
   stack_entry_type    stk_wdata, stk_rdata;

   logic               req_ready;
   logic               scan_last;

   assign rows_c = clamp_rows(csr_rows_ff);
   assign cols_c = clamp_cols(csr_cols_ff);
   assign total  = TOTAL_W'(rows_c) * TOTAL_W'(cols_c);

   // The sweep ends at the last cell of the grid in use.
   assign scan_last = (TOTAL_W'(scan_idx_ff) == total - TOTAL_W'(1));

   // Open bits of the loaded maze, addressed by row-major cell index.
   gml_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_open_ram (
      .clock (clock),
      .we    (open_we),
      .waddr (open_waddr),
      .wdata (open_wdata),
      .raddr (open_raddr),
      .rdata (open_rdata)
   );

   // Visited bits of the current walk; swept to zero before each walk.
   gml_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_vis_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (vis_waddr),
      .wdata (vis_wdata),
      .raddr (vis_raddr),
      .rdata (vis_rdata)
   );

   // Parent entries of the walk: each holds a cell and the direction it last tried.
   gml_ram #(.WIDTH($bits(stack_entry_type)), .DEPTH(CELL_COUNT)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // Neighbour arithmetic. The row and column of the top cell are carried alongside its
   // index, so the bounds tests need no division. Limits are strict, and columns are
   // bounded by the column count.
   always_comb begin
      nb_ok   = 1'b0;
      nb_cell = cur_cell_ff;
      nb_row  = cur_row_ff;
      nb_col  = cur_col_ff;
      unique case (cur_dir_ff)
         DIR_DOWN: begin
            nb_ok   = (DROW_W'(cur_row_ff) + DROW_W'(1)) < rows_c;
            nb_cell = cur_cell_ff + CELL_W'(cols_c);
            nb_row  = cur_row_ff + ROW_W'(1);
         end
         DIR_UP: begin
            nb_ok   = (cur_row_ff != '0);
            nb_cell = cur_cell_ff - CELL_W'(cols_c);
            nb_row  = cur_row_ff - ROW_W'(1);
         end
         DIR_RIGHT: begin
            nb_ok   = (DCOL_W'(cur_col_ff) + DCOL_W'(1)) < cols_c;
            nb_cell = cur_cell_ff + CELL_W'(1);
            nb_col  = cur_col_ff + COL_W'(1);
         end
         DIR_LEFT: begin
            nb_ok   = (cur_col_ff != '0);
            nb_cell = cur_cell_ff - CELL_W'(1);
            nb_col  = cur_col_ff - COL_W'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      load_pos_in   = load_pos_ff;
      walk2_in      = walk2_ff;
      scan_idx_in   = scan_idx_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      scan_pv_in    = 1'b0;
      found_in      = found_ff;
      start_cell_in = start_cell_ff;
      start_row_in  = start_row_ff;
      start_col_in  = start_col_ff;
      cur_cell_in   = cur_cell_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_dir_in    = cur_dir_ff;
      depth_in      = depth_ff;
      nb_cell_in    = nb_cell_ff;
      nb_row_in     = nb_row_ff;
      nb_col_in     = nb_col_ff;
      nb_dir_in     = nb_dir_ff;
      best_in       = best_ff;
      far_cell_in   = far_cell_ff;
      far_row_in    = far_row_ff;
      far_col_in    = far_col_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_len_in    = rsp_len_ff;
      rsp_none_in   = rsp_none_ff;
      req_ready     = 1'b0;

      open_we    = 1'b0;
      open_waddr = load_pos_ff[CELL_W-1:0];
      open_wdata = req_chan.cell_open;
      open_raddr = scan_idx_ff;
      vis_we     = 1'b0;
      vis_waddr  = scan_idx_ff;
      vis_wdata  = 1'b0;
      vis_raddr  = nb_cell;
      stk_we     = 1'b0;
      stk_waddr  = CELL_W'(depth_ff - TOTAL_W'(1));
      stk_wdata  = '{spot: cur_cell_ff, dir: nb_dir_ff};
      stk_raddr  = CELL_W'(depth_ff - TOTAL_W'(2));

      // The open bit read during the start scan arrives in the next cycle. The last loaded
      // open cell within the grid wins, so later hits overwrite earlier ones.
      if (scan_pv_ff && open_rdata && (TOTAL_W'(scan_pidx_ff) < load_pos_ff)) begin
         found_in      = 1'b1;
         start_cell_in = scan_pidx_ff;
         start_row_in  = scan_prow_ff;
         start_col_in  = scan_pcol_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               // Cells beyond the grid in use are dropped, but a last cell still starts.
               if (load_pos_ff < total) begin
                  open_we     = 1'b1;
                  load_pos_in = load_pos_ff + TOTAL_W'(1);
               end
               if (req_chan.last_cell) begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  scan_row_in = '0;
                  scan_col_in = '0;
                  found_in    = 1'b0;
                  walk2_in    = 1'b0;
               end
            end
         end

         ST_SCAN, ST_CLEAR: begin
            // Clear one visited bit a cycle; the first sweep also reads the open map.
            vis_we      = 1'b1;
            vis_waddr   = scan_idx_ff;
            vis_wdata   = 1'b0;
            open_raddr  = scan_idx_ff;
            scan_pv_in  = (state_ff == ST_SCAN);
            scan_idx_in = scan_idx_ff + CELL_W'(1);
            if (DCOL_W'(scan_col_ff) == cols_c - DCOL_W'(1)) begin
               scan_col_in = '0;
               scan_row_in = scan_row_ff + ROW_W'(1);
            end else begin
               scan_col_in = scan_col_ff + COL_W'(1);
            end
            if (scan_last) begin
               state_in = (state_ff == ST_SCAN) ? ST_SCAN_END : ST_SEED;
            end
         end

         ST_SCAN_END: begin
            // Lets the open bit of the final cell land before the start is chosen.
            state_in = ST_SEED;
         end

         ST_SEED: begin
            if (!walk2_ff && !found_ff) begin
               state_in = ST_RESULT;
            end else begin
               vis_we     = 1'b1;
               vis_wdata  = 1'b1;
               cur_dir_in = DIR_DOWN;
               depth_in   = TOTAL_W'(1);
               best_in    = '0;
               if (walk2_ff) begin
                  vis_waddr   = far_cell_ff;
                  cur_cell_in = far_cell_ff;
                  cur_row_in  = far_row_ff;
                  cur_col_in  = far_col_ff;
               end else begin
                  vis_waddr   = start_cell_ff;
                  cur_cell_in = start_cell_ff;
                  cur_row_in  = start_row_ff;
                  cur_col_in  = start_col_ff;
                  far_cell_in = start_cell_ff;
                  far_row_in  = start_row_ff;
                  far_col_in  = start_col_ff;
               end
               state_in = ST_EXPAND;
            end
         end

         ST_EXPAND: begin
            if (cur_dir_ff == DIR_DONE) begin
               if (depth_ff == TOTAL_W'(1)) begin
                  if (walk2_ff) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in    = ST_CLEAR;
                     walk2_in    = 1'b1;
                     scan_idx_in = '0;
                     scan_row_in = '0;
                     scan_col_in = '0;
                  end
               end else begin
                  // The parent entry is read now and restored in the pop cycle.
                  state_in = ST_POP;
               end
            end else begin
               cur_dir_in = dir_type'(3'(cur_dir_ff) + 3'd1);
               if (nb_ok && (TOTAL_W'(nb_cell) < load_pos_ff)) begin
                  open_raddr = nb_cell;
                  nb_cell_in = nb_cell;
                  nb_row_in  = nb_row;
                  nb_col_in  = nb_col;
                  nb_dir_in  = 2'(cur_dir_ff);
                  state_in   = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (open_rdata && !vis_rdata && (int'(depth_ff) < CELL_COUNT)) begin
               vis_we      = 1'b1;
               vis_waddr   = nb_cell_ff;
               vis_wdata   = 1'b1;
               stk_we      = 1'b1;
               cur_cell_in = nb_cell_ff;
               cur_row_in  = nb_row_ff;
               cur_col_in  = nb_col_ff;
               cur_dir_in  = DIR_DOWN;
               depth_in    = depth_ff + TOTAL_W'(1);
               // The new cell sits at the old stack depth; only a strictly deeper one counts.
               if (depth_ff > best_ff) begin
                  best_in     = depth_ff;
                  far_cell_in = nb_cell_ff;
                  far_row_in  = nb_row_ff;
                  far_col_in  = nb_col_ff;
               end
            end
            state_in = ST_EXPAND;
         end

         ST_POP: begin
            // The parent lies one step against the direction it had tried.
            cur_cell_in = stk_rdata.spot;
            cur_dir_in  = dir_type'({1'b0, stk_rdata.dir} + 3'd1);
            depth_in    = depth_ff - TOTAL_W'(1);
            unique case (stk_rdata.dir)
               2'(DIR_DOWN):  cur_row_in = cur_row_ff - ROW_W'(1);
               2'(DIR_UP):    cur_row_in = cur_row_ff + ROW_W'(1);
               2'(DIR_RIGHT): cur_col_in = cur_col_ff - COL_W'(1);
               2'(DIR_LEFT):  cur_col_in = cur_col_ff + COL_W'(1);
               default:       cur_row_in = cur_row_ff;
            endcase
            state_in = ST_EXPAND;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_none_in  = !walk2_ff;
               if (!walk2_ff) begin
                  rsp_len_in = '0;
               end else if (int'(best_ff) > LEN_MAX) begin
                  rsp_len_in = LEN_W'(LEN_MAX);
               end else begin
                  rsp_len_in = LEN_W'(best_ff);
               end
               load_pos_in = '0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register and other control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         scan_pv_ff   <= 1'b0;
         walk2_ff     <= 1'b0;
         found_ff     <= 1'b0;
         depth_ff     <= '0;
         best_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_pv_ff   <= scan_pv_in;
         walk2_ff     <= walk2_in;
         found_ff     <= found_in;
         depth_ff     <= depth_in;
         best_ff      <= best_in;
      end
   end

   // Datapath registers need no reset: each is written before it is used.
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      scan_row_ff   <= scan_row_in;
      scan_col_ff   <= scan_col_in;
      scan_pidx_ff  <= scan_idx_ff;
      scan_prow_ff  <= scan_row_ff;
      scan_pcol_ff  <= scan_col_ff;
      start_cell_ff <= start_cell_in;
      start_row_ff  <= start_row_in;
      start_col_ff  <= start_col_in;
      cur_cell_ff   <= cur_cell_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      cur_dir_ff    <= cur_dir_in;
      nb_cell_ff    <= nb_cell_in;
      nb_row_ff     <= nb_row_in;
      nb_col_ff     <= nb_col_in;
      nb_dir_ff     <= nb_dir_in;
      far_cell_ff   <= far_cell_in;
      far_row_ff    <= far_row_in;
      far_col_ff    <= far_col_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_none_ff   <= rsp_none_in;
   end

   // Configuration writes; a register keeps its raw value and is clamped where it is used.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_rows_ff <= CFG_DIM_RESET;
         csr_cols_ff <= CFG_DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_ROWS: csr_rows_ff <= csr_wdata;
            CSR_GRID_COLS: csr_cols_ff <= csr_wdata;
            default: begin
               csr_rows_ff <= csr_rows_ff;
            end
         endcase
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.path_length  = rsp_len_ff;
   assign rsp_chan.no_open_cell = rsp_none_ff;

   // A walk step always has a cell on top of the stack.
   `GML_ASSERT_IMPL(a_expand_nonempty, clock, reset, state_ff == ST_EXPAND, depth_ff != '0, "walk step with an empty stack")

   // Only cells that were loaded for this maze are ever probed.
   `GML_ASSERT_IMPL(a_probe_loaded, clock, reset, state_ff == ST_CHECK, TOTAL_W'(nb_cell_ff) < load_pos_ff, "probe of a cell that was not loaded")

   // A push writes the parent entry and deepens the stack by exactly one.
   `GML_ASSERT_NEXT(a_push_depth, clock, reset, state_ff == ST_CHECK && stk_we, depth_ff == $past(depth_ff) + TOTAL_W'(1), "push did not deepen the stack by one")

   // A pop restores the parent and leaves at least the start cell on the stack.
   `GML_ASSERT_NEXT(a_pop_depth, clock, reset, state_ff == ST_POP, depth_ff == $past(depth_ff) - TOTAL_W'(1) && depth_ff != '0, "pop left the stack inconsistent")

endmodule

@@ tb/tb_grid_maze_longest_path_core.sv @@
// Self-checking testbench for the grid maze longest path core, with its own maze solver.
`timescale 1ns / 1ps

module tb_grid_maze_longest_path_core;
   import gml_pkg::*;

   // Each random phase queues roughly this many cell requests; twelve phases give about 1800.
   localparam int PHASE_CELLS  = 150;
   localparam int PHASES       = 12;
   // Length of the one long receiver hold-off, in cycles.
   localparam int LONG_HOLD    = 400;
   // The slowest legal gap is a 64 by 64 start scan, two short walks and a clearing pass; the
   // limit allows many times that.
   localparam int QUIET_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 64;

   // Who idles during a phase: the sender lightly and the receiver heavily, the reverse, or nobody.
   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_RECEIVER_LIGHT,
      IDLE_NONE
   } idle_mode_type;

   typedef struct packed {
      logic open_bit;
      logic last_bit;
   } maze_cell_type;

   typedef struct packed {
      logic [LEN_W-1:0] path_length;
      logic             no_open_cell;
   } maze_answer_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   gml_req_if req_chan ();
   gml_rsp_if rsp_chan ();

   // Cell requests waiting to be offered, and the answers the solver expects, oldest first.
   maze_cell_type   pending_cells[$];
   maze_answer_type due_results[$];

   int   send_gap_pct;
   int   recv_gap_pct;
   logic long_hold_go;
   logic hold_taken;
   int   hold_left;
   int   mismatch_count;
   int   quiet_cycles;

   // Solver state: the register values in force, the cells of the maze being loaded, and the
   // scratch of the depth-first walk.
   logic [CFG_W-1:0]  rows_shadow;
   logic [CFG_W-1:0]  cols_shadow;
   logic              open_shadow [CELL_COUNT];
   bit                reached [CELL_COUNT];
   logic [CELL_W-1:0] trail_spot [CELL_COUNT];
   dir_type           trail_dir [CELL_COUNT];
   int                fill_count;
   int                deepest;
   int                deepest_spot;

   grid_maze_longest_path_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A register value of zero means one row or column; anything above the maximum means the
   // maximum.
   function automatic int span_in_use(input logic [CFG_W-1:0] v, input int hi);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > hi) begin
         return hi;
      end
      return int'(v);
   endfunction

   // Depth-first walk with an explicit stack that behaves exactly like the recursive version:
   // each stack entry remembers which neighbour it tries next, in the order down, up, right,
   // left. Only cells loaded for this maze and marked open may be entered. The first cell
   // reached at a strictly greater depth than any before it becomes the deepest spot.
   function automatic void dfs_sweep(input int origin, input int rows, input int cols);
      int      sp;
      int      top;
      int      here;
      int      r;
      int      c;
      int      nb;
      bit      ok;
      dir_type k;
      foreach (reached[j]) begin
         reached[j] = 1'b0;
      end
      reached[origin] = 1'b1;
      trail_spot[0]   = CELL_W'(origin);
      trail_dir[0]    = DIR_DOWN;
      sp              = 1;
      while (sp > 0) begin
         top  = sp - 1;
         here = int'(trail_spot[top]);
         k    = trail_dir[top];
         if (k == DIR_DONE) begin
            sp = sp - 1;
            continue;
         end
         trail_dir[top] = dir_type'(k + 3'd1);
         r  = here / cols;
         c  = here % cols;
         ok = 1'b0;
         nb = 0;
         case (k)
            DIR_DOWN: begin
               if (r + 1 < rows) begin
                  nb = here + cols;
                  ok = 1'b1;
               end
            end
            DIR_UP: begin
               if (r > 0) begin
                  nb = here - cols;
                  ok = 1'b1;
               end
            end
            DIR_RIGHT: begin
               if (c + 1 < cols) begin
                  nb = here + 1;
                  ok = 1'b1;
               end
            end
            default: begin
               if (c > 0) begin
                  nb = here - 1;
                  ok = 1'b1;
               end
            end
         endcase
         if (!ok || nb >= fill_count || nb >= rows * cols) begin
            continue;
         end
         if (open_shadow[nb] !== 1'b1 || reached[nb]) begin
            continue;
         end
         reached[nb]    = 1'b1;
         trail_spot[sp] = CELL_W'(nb);
         trail_dir[sp]  = DIR_DOWN;
         sp             = sp + 1;
         if (sp - 1 > deepest) begin
            deepest      = sp - 1;
            deepest_spot = nb;
         end
      end
   endfunction

   // Queues one maze given as a bit pattern, bit i being cell i; the final cell is marked last.
   task automatic queue_pattern(input logic [31:0] pattern, input int cells);
      int i;
      for (i = 0; i < cells; i++) begin
         pending_cells.push_back('{open_bit: pattern[i], last_bit: (i == cells - 1)});
      end
   endtask

   // Waits, sampling at the falling edge, until no request is queued or on offer and every
   // expected answer has arrived.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_cells.size() != 0 || req_chan.valid || due_results.size() != 0);
   endtask

   // Waits for the core to fall idle, lets any clearing pass run out, sets the idling of the
   // next phase and writes both grid dimensions.
   task automatic reconfigure(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] cv,
                              input idle_mode_type mode);
      int settle;
      wait_drained();
      settle = span_in_use(rows_shadow, MAX_ROWS) * span_in_use(cols_shadow, MAX_COLS) + 32;
      case (mode)
         IDLE_SENDER_LIGHT: begin
            send_gap_pct = 10;
            recv_gap_pct = 62;
         end
         IDLE_RECEIVER_LIGHT: begin
            send_gap_pct = 62;
            recv_gap_pct = 10;
         end
         default: begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
      endcase
      repeat (settle) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rv;
      @(posedge clock);
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cv;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Sender: a new request is offered only once the previous one has been taken, so valid
   // never drops while a request is pending.
   always @(posedge clock) begin : cell_sender
      maze_cell_type outgoing;
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.cell_open <= 1'b0;
         req_chan.last_cell <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_cells.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            outgoing = pending_cells.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.cell_open <= outgoing.open_bit;
            req_chan.last_cell <= outgoing.last_bit;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here so that the core fills up
   // and has to push back on the cell requests.
   always @(posedge clock) begin : answer_receiver
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
         hold_taken     <= 1'b0;
      end else if (long_hold_go && !hold_taken) begin
         hold_taken     <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Monitor: follows register writes, feeds each accepted cell request to the solver and
   // compares every accepted answer with the oldest expectation. It also counts cycles in
   // which no request and no answer moved, for the watchdog.
   always @(posedge clock) begin : solver_monitor
      int              rows_n;
      int              cols_n;
      int              total_n;
      int              origin;
      int              i;
      logic            moved;
      maze_answer_type want;
      if (reset) begin
         rows_shadow    = CFG_DIM_RESET;
         cols_shadow    = CFG_DIM_RESET;
         fill_count     = 0;
         quiet_cycles   = 0;
         mismatch_count = 0;
      end else begin
         moved = 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_ROWS: rows_shadow = csr_wdata;
               CSR_GRID_COLS: cols_shadow = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            moved   = 1'b1;
            rows_n  = span_in_use(rows_shadow, MAX_ROWS);
            cols_n  = span_in_use(cols_shadow, MAX_COLS);
            total_n = rows_n * cols_n;
            // Cells beyond a full grid are dropped, though a last mark on one still counts.
            if (fill_count < total_n) begin
               open_shadow[fill_count] = req_chan.cell_open;
               fill_count = fill_count + 1;
            end
            if (req_chan.last_cell) begin
               // The walks start from the last open cell in row-major order; cells never
               // loaded for this maze are treated as walls.
               origin = -1;
               for (i = 0; i < fill_count; i++) begin
                  if (open_shadow[i] === 1'b1) begin
                     origin = i;
                  end
               end
               if (origin < 0) begin
                  want.path_length  = '0;
                  want.no_open_cell = 1'b1;
               end else begin
                  deepest      = 0;
                  deepest_spot = origin;
                  dfs_sweep(origin, rows_n, cols_n);
                  deepest = 0;
                  dfs_sweep(deepest_spot, rows_n, cols_n);
                  want.path_length  = (deepest > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(deepest);
                  want.no_open_cell = 1'b0;
               end
               due_results.push_back(want);
               fill_count = 0;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (due_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: unexpected answer, path_length %0d no_open_cell %0b",
                        $time, rsp_chan.path_length, rsp_chan.no_open_cell);
            end else begin
               want = due_results.pop_front();
               if (rsp_chan.path_length !== want.path_length) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%0t: path_length expected %0d actual %0d",
                           $time, want.path_length, rsp_chan.path_length);
               end
               if (rsp_chan.no_open_cell !== want.no_open_cell) begin
                  mismatch_count = mismatch_count + 1;
                  $display("%0t: no_open_cell expected %0b actual %0b",
                           $time, want.no_open_cell, rsp_chan.no_open_cell);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog: ends the run once nothing has moved for far longer than any legal pause.
   initial begin
      do begin
         @(negedge clock);
      end while (quiet_cycles < QUIET_LIMIT);
      $display("tb_grid_maze_longest_path_core: errors");
      $finish;
   end

   // Stimulus: a short directed part, then random phases, each with its own grid size and
   // idling, and finally the verdict.
   initial begin
      int               p;
      int               i;
      int               rows_n;
      int               cols_n;
      int               total_n;
      int               cells_n;
      int               pct_n;
      int               queued_n;
      logic [CFG_W-1:0] rv;
      logic [CFG_W-1:0] cv;
      long_hold_go        = 1'b0;
      send_gap_pct        = 10;
      recv_gap_pct        = 62;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_GRID_ROWS;
      csr_wdata          <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset grid of 64 by 64: a lone open cell, a lone wall, and a short row of
      // open cells where the rest of the grid was never loaded and so counts as wall.
      queue_pattern(32'h1, 1);
      queue_pattern(32'h0, 1);
      queue_pattern(32'h3F, 6);

      // Zero in both registers means a single cell; the later cells overflow the grid and are
      // dropped, so only the first one decides the answer.
      reconfigure(7'd0, 7'd0, IDLE_SENDER_LIGHT);
      queue_pattern(32'h5, 3);
      queue_pattern(32'h6, 3);

      // All ones clamps the rows to the maximum; a single column walks straight down.
      reconfigure(7'd127, 7'd1, IDLE_SENDER_LIGHT);
      queue_pattern(32'h1F, 5);

      // A fully open two by three grid, where the deepest spot of the first walk matters.
      reconfigure(7'd2, 7'd3, IDLE_SENDER_LIGHT);
      queue_pattern(32'h3F, 6);

      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin
               rv = CFG_W'($urandom_range(1, 8));
               cv = CFG_W'($urandom_range(1, 8));
            end
            1: begin
               rv = CFG_W'($urandom_range(1, 6));
               cv = CFG_W'($urandom_range(1, 12));
            end
            2: begin
               if (p == 2) begin
                  rv = 7'd64;
                  cv = 7'd2;
               end else if (p == 6) begin
                  rv = 7'd1;
                  cv = 7'd100;
               end else begin
                  rv = 7'd127;
                  cv = 7'd127;
               end
            end
            default: begin
               rv = CFG_W'($urandom_range(0, 10));
               cv = CFG_W'($urandom_range(0, 10));
            end
         endcase
         reconfigure(rv, cv, idle_mode_type'(p / 4));
         if (p == 8) begin
            long_hold_go = 1'b1;
         end
         rows_n   = span_in_use(rv, MAX_ROWS);
         cols_n   = span_in_use(cv, MAX_COLS);
         total_n  = rows_n * cols_n;
         queued_n = 0;
         while (queued_n < PHASE_CELLS) begin
            // Mostly complete mazes; some stop short and some run past the end of the grid.
            // On the largest grids only short mazes are sent, to keep the run brief.
            if (total_n > 256) begin
               cells_n = $urandom_range(1, 48);
            end else begin
               case ($urandom_range(9))
                  0:       cells_n = $urandom_range(1, total_n);
                  1:       cells_n = total_n + $urandom_range(1, 4);
                  default: cells_n = total_n;
               endcase
            end
            case ($urandom_range(9))
               0:       pct_n = 0;
               1:       pct_n = 100;
               default: pct_n = $urandom_range(45, 95);
            endcase
            for (i = 0; i < cells_n; i++) begin
               pending_cells.push_back('{open_bit: ($urandom_range(99) < pct_n),
                                         last_bit: (i == cells_n - 1)});
            end
            queued_n = queued_n + cells_n;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("tb_grid_maze_longest_path_core: clean");
      end else begin
         $display("tb_grid_maze_longest_path_core: errors");
      end
      $finish;
   end

endmodule
